/* rtl/rtn_pkg.sv */
package rtn_pkg;

    localparam int CHAR_W = 8;
    localparam int DUR_W  = 10;
    localparam int OCT_W  = 4;
    localparam int BPM_W  = 10;
    localparam int DDUR_W = 8;
    localparam int HZ_W   = 15;
    localparam int NOTE_W = 8;
    localparam int MS_W   = 19;
    localparam int DEN_W  = 20;
    localparam int DIV_CNT_W = 5;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 48;
    localparam int APB_ADDR_W  = 4;
    localparam int APB_DATA_W  = 32;

    localparam logic [1:0] REG_DEF_DUR = 2'd0;
    localparam logic [1:0] REG_DEF_OCT = 2'd1;
    localparam logic [1:0] REG_BPM     = 2'd2;

    localparam logic [DDUR_W-1:0] RST_DEF_DUR = 8'd4;
    localparam logic [OCT_W-1:0]  RST_DEF_OCT = 4'd6;
    localparam logic [BPM_W-1:0]  RST_BPM     = 10'd120;

    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] CH_SHARP   = 8'h23;
    localparam logic [CHAR_W-1:0] CH_COMMA   = 8'h2C;
    localparam logic [CHAR_W-1:0] CH_DOT     = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_CASE    = 8'h20;
    localparam logic [CHAR_W-1:0] CH_LOW_P   = 8'h70;

    localparam logic [13:0]       DUR_MAX  = 14'd999;
    localparam logic [NOTE_W-1:0] NOTE_MAX = 8'd132;
    localparam logic [NOTE_W-1:0] NOTE_MIN = 8'd12;
    localparam logic [NOTE_W-1:0] SEMIS_PER_OCT = 8'd12;
    localparam logic [MS_W-1:0]   WHOLE_MS  = 19'd240000;
    localparam logic [MS_W-1:0]   DOTTED_MS = 19'd360000;

    localparam logic [HZ_W-1:0] PITCH_HZ [0:120] = '{
        15'd16, 15'd17, 15'd18, 15'd19, 15'd20, 15'd21, 15'd23, 15'd24,
        15'd25, 15'd27, 15'd29, 15'd30,
        15'd32, 15'd34, 15'd36, 15'd38, 15'd41, 15'd43, 15'd46, 15'd48,
        15'd51, 15'd55, 15'd58, 15'd61,
        15'd65, 15'd69, 15'd73, 15'd77, 15'd82, 15'd87, 15'd92, 15'd97,
        15'd103, 15'd110, 15'd116, 15'd123,
        15'd130, 15'd138, 15'd146, 15'd155, 15'd164, 15'd174, 15'd184, 15'd195,
        15'd207, 15'd220, 15'd233, 15'd246,
        15'd261, 15'd277, 15'd293, 15'd311, 15'd329, 15'd349, 15'd369, 15'd391,
        15'd415, 15'd440, 15'd466, 15'd493,
        15'd523, 15'd554, 15'd587, 15'd622, 15'd659, 15'd698, 15'd739, 15'd783,
        15'd830, 15'd880, 15'd932, 15'd987,
        15'd1046, 15'd1108, 15'd1174, 15'd1244, 15'd1318, 15'd1396, 15'd1479,
        15'd1567, 15'd1661, 15'd1760, 15'd1864, 15'd1975,
        15'd2093, 15'd2217, 15'd2349, 15'd2489, 15'd2637, 15'd2793, 15'd2959,
        15'd3135, 15'd3322, 15'd3520, 15'd3729, 15'd3951,
        15'd4186, 15'd4434, 15'd4698, 15'd4978, 15'd5274, 15'd5587, 15'd5919,
        15'd6271, 15'd6644, 15'd7040, 15'd7458, 15'd7902,
        15'd8372, 15'd8869, 15'd9397, 15'd9956, 15'd10548, 15'd11175, 15'd11839,
        15'd12543, 15'd13289, 15'd14080, 15'd14917, 15'd15804,
        15'd16744
    };

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_DIGITS,
        PH_LETTER,
        PH_MODS
    } t_phase;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MULT,
        ST_START,
        ST_DIV,
        ST_SEND
    } t_state;

    typedef struct packed {
        logic [DDUR_W-1:0] def_dur;
        logic [OCT_W-1:0]  def_oct;
        logic [BPM_W-1:0]  bpm;
    } t_cfg;

    typedef struct packed {
        logic accept;
        logic mult;
        logic div_start;
        logic reload;
    } t_cmd;

    typedef struct packed {
        logic emit_close;
        logic emit_final;
        logic div_busy;
    } t_sts;

    // Bit 4 flags a pitched letter, bits 3:0 give its semitone within the octave.
    function automatic logic [4:0] semitone_of(input logic [CHAR_W-1:0] letter);
        logic [4:0] res;
        case (letter)
            8'h63:   res = 5'h10;
            8'h64:   res = 5'h12;
            8'h65:   res = 5'h14;
            8'h66:   res = 5'h15;
            8'h67:   res = 5'h17;
            8'h61:   res = 5'h19;
            8'h62:   res = 5'h1B;
            default: res = 5'h00;
        endcase
        return res;
    endfunction

endpackage

/* rtl/rtn_regs.sv */
module rtn_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [rtn_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [rtn_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [rtn_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready,
    output rtn_pkg::t_cfg                    o_cfg
);
    import rtn_pkg::*;

    logic [DDUR_W-1:0] r_def_dur;
    logic [OCT_W-1:0]  r_def_oct;
    logic [BPM_W-1:0]  r_bpm;
    logic              w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_def_dur <= RST_DEF_DUR;
            r_def_oct <= RST_DEF_OCT;
            r_bpm     <= RST_BPM;
        end else if (w_wr) begin
            case (paddr[3:2])
                REG_DEF_DUR: r_def_dur <= pwdata[DDUR_W-1:0];
                REG_DEF_OCT: r_def_oct <= pwdata[OCT_W-1:0];
                REG_BPM:     r_bpm     <= pwdata[BPM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_DEF_DUR: prdata = {{(APB_DATA_W-DDUR_W){1'b0}}, r_def_dur};
            REG_DEF_OCT: prdata = {{(APB_DATA_W-OCT_W){1'b0}}, r_def_oct};
            REG_BPM:     prdata = {{(APB_DATA_W-BPM_W){1'b0}}, r_bpm};
            default:     prdata = '0;
        endcase
    end

    assign o_cfg.def_dur = r_def_dur;
    assign o_cfg.def_oct = r_def_oct;
    assign o_cfg.bpm     = r_bpm;

endmodule

/* rtl/rtn_div.sv */
module rtn_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [rtn_pkg::MS_W-1:0]    i_num,
    input  logic [rtn_pkg::DEN_W-1:0]   i_den,
    output logic                        o_busy,
    output logic [rtn_pkg::MS_W-1:0]    o_quo
);
    import rtn_pkg::*;

    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DEN_W-1:0]     r_rem;
    logic [MS_W-1:0]      r_quo;
    logic [DEN_W:0]       w_trial;
    logic [DEN_W:0]       w_diff;

    // Restoring division, one quotient bit per cycle; the quotient shifts in
    // behind the dividend bits as they are consumed.
    assign w_trial = {r_rem, r_quo[MS_W-1]};
    assign w_diff  = w_trial - {1'b0, i_den};
    assign o_busy  = (r_cnt != '0);
    assign o_quo   = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= DIV_CNT_W'(MS_W);
        end else if (o_busy) begin
            r_cnt <= r_cnt - DIV_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
        end else if (o_busy) begin
            if (!w_diff[DEN_W]) begin
                r_rem <= w_diff[DEN_W-1:0];
                r_quo <= {r_quo[MS_W-2:0], 1'b1};
            end else begin
                r_rem <= w_trial[DEN_W-1:0];
                r_quo <= {r_quo[MS_W-2:0], 1'b0};
            end
        end
    end

endmodule

/* rtl/rtn_dp.sv */
module rtn_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  rtn_pkg::t_cfg                     i_cfg,
    input  rtn_pkg::t_cmd                     i_cmd,
    input  logic [rtn_pkg::CHAR_W-1:0]        i_char,
    input  logic                              i_final,
    output rtn_pkg::t_sts                     o_sts,
    output logic [rtn_pkg::OUT_TDATA_W-1:0]   o_tdata
);
    import rtn_pkg::*;

    // Open token.
    t_phase             r_phase;
    logic [DUR_W-1:0]   r_dur;
    logic [CHAR_W-1:0]  r_letter;
    logic               r_sharp;
    logic [OCT_W-1:0]   r_oct;
    logic               r_dot;

    t_phase             n_phase;
    logic [DUR_W-1:0]   n_dur;
    logic [CHAR_W-1:0]  n_letter;
    logic               n_sharp;
    logic [OCT_W-1:0]   n_oct;
    logic               n_dot;

    // Token being turned into a note event.
    logic [DUR_W-1:0]   r_e_dur;
    logic [CHAR_W-1:0]  r_e_letter;
    logic               r_e_sharp;
    logic [OCT_W-1:0]   r_e_oct;
    logic               r_e_dot;

    logic [DEN_W-1:0]   r_prod;
    logic [MS_W-1:0]    r_num;
    logic [NOTE_W-1:0]  r_note;
    logic [HZ_W-1:0]    r_hz;

    logic [CHAR_W-1:0]  w_c;
    logic               w_digit;
    logic               w_done;
    logic               w_close;
    logic [13:0]        w_acc;
    logic [DUR_W-1:0]   w_dur_eff;
    logic [BPM_W-1:0]   w_bpm_eff;
    logic [4:0]         w_semi;
    logic [NOTE_W-1:0]  w_note_raw;
    logic [NOTE_W-1:0]  w_note;
    logic [NOTE_W-1:0]  w_idx;
    logic               w_busy;
    logic [MS_W-1:0]    w_quo;

    always_comb begin
        w_c = i_char;
        if (i_char >= CH_UPPER_A && i_char <= CH_UPPER_Z) begin
            w_c = i_char + CH_CASE;
        end
        w_digit = (w_c >= CH_ZERO) && (w_c <= CH_NINE);
    end

    always_comb begin
        n_phase  = r_phase;
        n_dur    = r_dur;
        n_letter = r_letter;
        n_sharp  = r_sharp;
        n_oct    = r_oct;
        n_dot    = r_dot;
        w_done   = 1'b0;
        w_close  = 1'b0;
        w_acc    = '0;
        if (w_c != CH_SPACE) begin
            if (r_phase == PH_LETTER || r_phase == PH_MODS) begin
                if (r_phase == PH_LETTER && w_c == CH_SHARP) begin
                    n_sharp = 1'b1;
                    n_phase = PH_MODS;
                    w_done  = 1'b1;
                end else if (w_digit) begin
                    n_oct   = w_c[OCT_W-1:0];
                    n_phase = PH_MODS;
                    w_done  = 1'b1;
                end else if (w_c == CH_DOT) begin
                    n_dot   = 1'b1;
                    n_phase = PH_MODS;
                    w_done  = 1'b1;
                end else begin
                    w_close = 1'b1;
                    n_phase = PH_IDLE;
                    w_done  = (w_c == CH_COMMA);
                end
            end
            if (!w_done) begin
                // A character arriving with no open token starts a fresh one.
                if (n_phase == PH_IDLE) begin
                    n_dur    = '0;
                    n_letter = '0;
                    n_sharp  = 1'b0;
                    n_dot    = 1'b0;
                    n_oct    = i_cfg.def_oct;
                end
                if (w_digit) begin
                    w_acc = {4'd0, n_dur} * 14'd10 + {10'd0, w_c[3:0]};
                    n_dur = (w_acc > DUR_MAX) ? DUR_MAX[DUR_W-1:0] : w_acc[DUR_W-1:0];
                    n_phase = PH_DIGITS;
                end else begin
                    n_letter = w_c;
                    n_phase  = PH_LETTER;
                end
            end
        end
        if (i_final && n_phase == PH_DIGITS) begin
            n_letter = CH_LOW_P;
        end
    end

    assign o_sts.emit_close = w_close;
    assign o_sts.emit_final = i_final && (n_phase != PH_IDLE);
    assign o_sts.div_busy   = w_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_dur    <= '0;
            r_letter <= '0;
            r_sharp  <= 1'b0;
            r_oct    <= RST_DEF_OCT;
            r_dot    <= 1'b0;
        end else if (i_cmd.accept) begin
            r_phase  <= i_final ? PH_IDLE : n_phase;
            r_dur    <= n_dur;
            r_letter <= n_letter;
            r_sharp  <= n_sharp;
            r_oct    <= n_oct;
            r_dot    <= n_dot;
        end
    end

    // The token closed by this character goes first; the token ended by the
    // last character follows from the updated state.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && w_close) begin
            r_e_dur    <= r_dur;
            r_e_letter <= r_letter;
            r_e_sharp  <= r_sharp;
            r_e_oct    <= r_oct;
            r_e_dot    <= r_dot;
        end else if (i_cmd.accept) begin
            r_e_dur    <= n_dur;
            r_e_letter <= n_letter;
            r_e_sharp  <= n_sharp;
            r_e_oct    <= n_oct;
            r_e_dot    <= n_dot;
        end else if (i_cmd.reload) begin
            r_e_dur    <= r_dur;
            r_e_letter <= r_letter;
            r_e_sharp  <= r_sharp;
            r_e_oct    <= r_oct;
            r_e_dot    <= r_dot;
        end
    end

    always_comb begin
        if (r_e_dur != '0) begin
            w_dur_eff = r_e_dur;
        end else if (i_cfg.def_dur != '0) begin
            w_dur_eff = {{(DUR_W-DDUR_W){1'b0}}, i_cfg.def_dur};
        end else begin
            w_dur_eff = DUR_W'(1);
        end
        w_bpm_eff  = (i_cfg.bpm != '0) ? i_cfg.bpm : BPM_W'(1);
        w_semi     = semitone_of(r_e_letter);
        w_note_raw = ({4'd0, r_e_oct} + 8'd1) * SEMIS_PER_OCT
                   + {4'd0, w_semi[3:0]} + {7'd0, r_e_sharp};
        w_note     = (w_note_raw > NOTE_MAX) ? NOTE_MAX : w_note_raw;
        w_idx      = w_note - NOTE_MIN;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mult) begin
            r_prod <= {{(DEN_W-DUR_W){1'b0}}, w_dur_eff} * {{(DEN_W-BPM_W){1'b0}}, w_bpm_eff};
            r_num  <= r_e_dot ? DOTTED_MS : WHOLE_MS;
            if (w_semi[4]) begin
                r_note <= w_note;
                r_hz   <= PITCH_HZ[w_idx[6:0]];
            end else begin
                r_note <= '0;
                r_hz   <= '0;
            end
        end
    end

    rtn_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (r_num),
        .i_den   (r_prod),
        .o_busy  (w_busy),
        .o_quo   (w_quo)
    );

    assign o_tdata = {{(OUT_TDATA_W-MS_W-NOTE_W-HZ_W){1'b0}}, w_quo, r_note, r_hz};

endmodule

/* rtl/rtn_ctrl.sv */
module rtn_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_out_ready,
    input  rtn_pkg::t_sts   i_sts,
    output rtn_pkg::t_cmd   o_cmd,
    output logic            o_in_ready,
    output logic            o_out_valid,
    output logic            o_out_last
);
    import rtn_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_more;
    logic   w_accept;
    logic   w_sent;

    assign w_accept = (r_state == ST_IDLE) && i_in_valid;
    assign w_sent   = (r_state == ST_SEND) && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_more  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_more <= i_sts.emit_close && i_sts.emit_final;
            end else if (w_sent) begin
                r_more <= 1'b0;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid && (i_sts.emit_close || i_sts.emit_final)) begin
                    n_state = ST_MULT;
                end
            end
            ST_MULT:  n_state = ST_START;
            ST_START: n_state = ST_DIV;
            ST_DIV: begin
                if (!i_sts.div_busy) begin
                    n_state = ST_SEND;
                end
            end
            ST_SEND: begin
                if (i_out_ready) begin
                    n_state = r_more ? ST_MULT : ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_out_last  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            ST_MULT:  o_cmd.mult = 1'b1;
            ST_START: o_cmd.div_start = 1'b1;
            ST_DIV: ;
            ST_SEND: begin
                o_out_valid  = 1'b1;
                o_out_last   = !r_more;
                o_cmd.reload = i_out_ready && r_more;
            end
            default: ;
        endcase
    end

endmodule

/* rtl/rtttl_note_tokenizer_unit.sv */
// Channel   Direction  Contents
// s_axis    in         tdata[7:0] character, tlast final_char
// m_axis    out        tdata tone_hz, semitone_number, length_ms; tlast run_end
// apb       in/out     0x0 default_duration, 0x4 default_octave, 0x8 beats_per_minute
//
// One character is taken per transaction when the block is idle; a character
// that completes no note leaves the block idle for the next character.
// Each note event then steps through the controller states in order: the tempo
// times length product, loading the divider, the one-bit-per-cycle division
// until the divider finishes, and offering the event until m_axis_tready;
// a character may cause two events.
// Synchronous active-low reset puts the tokenizer idle with no open token.
// s_axis_tready stays low until every event of the last character has left.
module rtttl_note_tokenizer_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [rtn_pkg::IN_TDATA_W-1:0]      s_axis_tdata,   // [7:0] character
    input  logic                                s_axis_tlast,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [14:0] tone_hz, [22:15] semitone_number, [41:23] length_ms, [47:42] zero
    output logic [rtn_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    output logic                                m_axis_tlast,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rtn_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [rtn_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [rtn_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready
);
    import rtn_pkg::*;

    t_cfg w_cfg;
    t_cmd w_cmd;
    t_sts w_sts;

    rtn_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    rtn_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_last  (m_axis_tlast)
    );

    rtn_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_cmd   (w_cmd),
        .i_char  (s_axis_tdata[CHAR_W-1:0]),
        .i_final (s_axis_tlast),
        .o_sts   (w_sts),
        .o_tdata (m_axis_tdata)
    );

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input taken while a note event is pending");

    a_div_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.div_start |-> !w_sts.div_busy)
        else $error("divider restarted while busy");

    a_second_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> !s_axis_tready)
        else $error("input taken before the second note event");

    a_silent_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && !w_sts.emit_close && !w_sts.emit_final)
        |=> s_axis_tready)
        else $error("character without events did not finish in one cycle");

endmodule

/* tb/rtttl_note_tokenizer_unit_tb.sv */
`timescale 1ns / 100ps

module rtttl_note_tokenizer_unit_tb;
    import rtn_pkg::*;

    localparam int WHOLE_NOTE_MS    = 240000;
    localparam int DOTTED_WHOLE_MS  = 360000;
    localparam int LONGEST_COUNT    = 999;
    localparam int TOP_NOTE         = 132;
    localparam int FIRST_NOTE       = 12;
    localparam int OCTAVE_STEPS     = 12;
    localparam int RESET_DURATION   = 4;
    localparam int RESET_OCTAVE     = 6;
    localparam int RESET_TEMPO      = 120;
    localparam int SETTLE_CYCLES    = 40;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int PHASE_ITEMS      = 240;
    localparam int PHASE_COUNT      = 7;
    localparam int PRINT_CAP        = 100;
    localparam int RUN_LIMIT_NS     = 12_000_000;

    // Whole-Hz tone for each note number from 12 up to 132.
    localparam int TONE_TABLE [0:120] = '{
        16, 17, 18, 19, 20, 21, 23, 24, 25, 27, 29, 30,
        32, 34, 36, 38, 41, 43, 46, 48, 51, 55, 58, 61,
        65, 69, 73, 77, 82, 87, 92, 97, 103, 110, 116, 123,
        130, 138, 146, 155, 164, 174, 184, 195, 207, 220, 233, 246,
        261, 277, 293, 311, 329, 349, 369, 391, 415, 440, 466, 493,
        523, 554, 587, 622, 659, 698, 739, 783, 830, 880, 932, 987,
        1046, 1108, 1174, 1244, 1318, 1396, 1479, 1567, 1661, 1760, 1864, 1975,
        2093, 2217, 2349, 2489, 2637, 2793, 2959, 3135, 3322, 3520, 3729, 3951,
        4186, 4434, 4698, 4978, 5274, 5587, 5919, 6271, 6644, 7040, 7458, 7902,
        8372, 8869, 9397, 9956, 10548, 11175, 11839, 12543, 13289, 14080, 14917, 15804,
        16744
    };

    typedef struct packed {
        logic [HZ_W-1:0]   hz;
        logic [NOTE_W-1:0] note;
        logic [MS_W-1:0]   ms;
        logic              last;
    } t_note;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              fin;
        logic              typed;
        t_note             want;
    } t_script_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   s_axis_tlast = 1'b0;
    logic                   m_axis_tready = 1'b0;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [APB_ADDR_W-1:0]  paddr = '0;
    logic [APB_DATA_W-1:0]  pwdata = '0;
    logic                   s_axis_tready;
    logic                   m_axis_tvalid;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tlast;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    // Tokenizer state and register copies kept by the predictor.
    t_phase            tok_phase;
    int                dur_count;
    logic [CHAR_W-1:0] tok_letter;
    logic              tok_sharp;
    logic [OCT_W-1:0]  tok_octave;
    logic              tok_dot;
    logic [DDUR_W-1:0] cfg_duration;
    logic [OCT_W-1:0]  cfg_octave;
    logic [BPM_W-1:0]  cfg_tempo;

    t_note       notes_due[$];
    t_script_row melody_script[$];
    int          mismatch_count = 0;
    int          stall_asked = 0;
    int          stall_served = 0;
    int          sink_hold = 0;
    bit          src_calm = 1'b0;
    bit          sink_calm = 1'b0;

    rtttl_note_tokenizer_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("DONE: errors detected");
        $finish;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP) begin
            $display("%0t: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
        end
    endtask

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99);
        if (roll < 55) return 0;
        if (roll < 88) return $urandom_range(3, 1);
        if (roll < 97) return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    function automatic int semitone_in_octave(input logic [CHAR_W-1:0] letter);
        case (letter)
            "c": return 0;
            "d": return 2;
            "e": return 4;
            "f": return 5;
            "g": return 7;
            "a": return 9;
            "b": return 11;
            default: return -1;
        endcase
    endfunction

    function automatic void open_token();
        dur_count  = 0;
        tok_letter = '0;
        tok_sharp  = 1'b0;
        tok_dot    = 1'b0;
        tok_octave = cfg_octave;
    endfunction

    function automatic t_note finished_note();
        t_note r;
        int    semi;
        int    count;
        int    tempo;
        int    midi;
        r     = '0;
        semi  = semitone_in_octave(tok_letter);
        count = (dur_count != 0) ? dur_count : int'(cfg_duration);
        if (count == 0) count = 1;
        tempo = (cfg_tempo != 0) ? int'(cfg_tempo) : 1;
        if (semi >= 0) begin
            midi = (int'(tok_octave) + 1) * OCTAVE_STEPS + semi + int'(tok_sharp);
            if (midi > TOP_NOTE) midi = TOP_NOTE;
            r.note = NOTE_W'(midi);
            r.hz   = HZ_W'(TONE_TABLE[midi - FIRST_NOTE]);
        end
        r.ms = MS_W'((tok_dot ? DOTTED_WHOLE_MS : WHOLE_NOTE_MS) / (tempo * count));
        return r;
    endfunction

    // Advances the tokenizer by one character and queues the note events it closes.
    function automatic int predict_notes(input logic [CHAR_W-1:0] raw, input logic fin);
        logic [CHAR_W-1:0] c;
        logic              digit;
        logic              done;
        t_note             ev[2];
        int                n;
        c     = raw;
        n     = 0;
        done  = 1'b0;
        digit = 1'b0;
        if (c != CH_SPACE) begin
            if (c >= CH_UPPER_A && c <= CH_UPPER_Z) c = c + CH_CASE;
            digit = (c >= CH_ZERO && c <= CH_NINE);
            if (tok_phase == PH_LETTER || tok_phase == PH_MODS) begin
                if (tok_phase == PH_LETTER && c == CH_SHARP) begin
                    tok_sharp = 1'b1;
                    tok_phase = PH_MODS;
                    done = 1'b1;
                end else if (digit) begin
                    tok_octave = OCT_W'(c - CH_ZERO);
                    tok_phase = PH_MODS;
                    done = 1'b1;
                end else if (c == CH_DOT) begin
                    tok_dot = 1'b1;
                    tok_phase = PH_MODS;
                    done = 1'b1;
                end else begin
                    ev[n] = finished_note();
                    n++;
                    tok_phase = PH_IDLE;
                    done = (c == CH_COMMA);
                end
            end
            if (!done) begin
                if (tok_phase == PH_IDLE) open_token();
                if (digit) begin
                    dur_count = dur_count * 10 + int'(c - CH_ZERO);
                    if (dur_count > LONGEST_COUNT) dur_count = LONGEST_COUNT;
                    tok_phase = PH_DIGITS;
                end else begin
                    tok_letter = c;
                    tok_phase = PH_LETTER;
                end
            end
        end
        if (fin && tok_phase != PH_IDLE) begin
            // A token holding only digits ends as a rest.
            if (tok_phase == PH_DIGITS) tok_letter = CH_LOW_P;
            ev[n] = finished_note();
            n++;
        end
        if (fin) tok_phase = PH_IDLE;
        if (n > 0) ev[n-1].last = 1'b1;
        for (int i = 0; i < n; i++) notes_due.push_back(ev[i]);
        return n;
    endfunction

    task automatic check_note();
        t_note want;
        if (notes_due.size() == 0) begin
            report_mismatch("note event with none due, tone_hz", m_axis_tdata[14:0], 0);
        end else begin
            want = notes_due.pop_front();
            if (m_axis_tdata[14:0] != want.hz)
                report_mismatch("tone_hz", m_axis_tdata[14:0], want.hz);
            if (m_axis_tdata[22:15] != want.note)
                report_mismatch("semitone_number", m_axis_tdata[22:15], want.note);
            if (m_axis_tdata[41:23] != want.ms)
                report_mismatch("length_ms", m_axis_tdata[41:23], want.ms);
            if (m_axis_tlast != want.last)
                report_mismatch("run_end", m_axis_tlast, want.last);
            if (m_axis_tdata[47:42] != '0)
                report_mismatch("tdata padding", m_axis_tdata[47:42], 0);
        end
    endtask

    // Result side: checks each transaction and drops tready at random or for a long hold on request.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) check_note();
        if (stall_served != stall_asked) begin
            stall_served = stall_asked;
            sink_hold = LONG_HOLD_CYCLES;
        end else if (sink_hold == 0 && !sink_calm && $urandom_range(7) == 0) begin
            sink_hold = pick_gap();
        end
        if (sink_hold > 0) begin
            sink_hold--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic send_char(input logic [CHAR_W-1:0] c, input logic fin, output int produced);
        int gap;
        gap = src_calm ? 0 : pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= fin;
        do @(posedge i_clk); while (!s_axis_tready);
        produced = predict_notes(c, fin);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [APB_DATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_DEF_DUR: cfg_duration = val[DDUR_W-1:0];
            REG_DEF_OCT: cfg_octave   = val[OCT_W-1:0];
            REG_BPM:     cfg_tempo    = val[BPM_W-1:0];
            default: ;
        endcase
        // Read the register straight back; psel stays high into the next setup phase.
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata != val) report_mismatch("register readback", prdata, val);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (notes_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One melody: mostly well-formed tokens, some noise bytes and broken endings.
    task automatic play_tune(inout int sent);
        logic [CHAR_W-1:0] tune[$];
        logic [CHAR_W-1:0] ch;
        string             pitched = "abcdefgp";
        int                tokens;
        int                digits;
        int                ending;
        int                produced;
        bit                with_octave;
        bit                with_dot;
        bit                dot_first;
        tokens = $urandom_range(8, 1);
        for (int t = 0; t < tokens; t++) begin
            if ($urandom_range(99) < 8) begin
                tune.push_back(CHAR_W'($urandom_range(255)));
            end else begin
                if ($urandom_range(99) < 50) digits = 0;
                else if ($urandom_range(99) < 90) digits = $urandom_range(2, 1);
                else digits = $urandom_range(5, 3);
                repeat (digits) tune.push_back(CH_ZERO + CHAR_W'($urandom_range(9)));
                if ($urandom_range(99) < 5) tune.push_back(CH_SPACE);
                if ($urandom_range(99) < 90) ch = pitched[$urandom_range(7)];
                else ch = "h" + CHAR_W'($urandom_range(18));
                if ($urandom_range(1) == 1) ch = ch - CH_CASE;
                tune.push_back(ch);
                if ($urandom_range(99) < 30) tune.push_back(CH_SHARP);
                with_octave = ($urandom_range(99) < 55);
                with_dot    = ($urandom_range(99) < 25);
                dot_first   = $urandom_range(1);
                if (with_dot && dot_first) tune.push_back(CH_DOT);
                if (with_octave) tune.push_back(CH_ZERO + CHAR_W'($urandom_range(9)));
                if (with_dot && !dot_first) tune.push_back(CH_DOT);
                if ($urandom_range(99) < 5) tune.push_back(CH_SHARP);
                if ($urandom_range(99) < 85) tune.push_back(CH_COMMA);
                if ($urandom_range(99) < 15) tune.push_back(CH_SPACE);
            end
        end
        ending = $urandom_range(9);
        if (ending < 2) begin
            tune.push_back(CH_SPACE);
        end else if (ending < 5) begin
            // Leave the last token open when the melody ends.
            repeat ($urandom_range(2, 1)) if (tune.size() > 1) void'(tune.pop_back());
        end
        foreach (tune[i]) begin
            send_char(tune[i], i == tune.size() - 1, produced);
            if (tune[i] != CH_SPACE) sent++;
        end
    endtask

    function automatic t_script_row step_row(input logic [CHAR_W-1:0] c, input logic fin,
            input logic typed = 1'b0, input int hz = 0, input int note = 0, input int ms = 0);
        t_script_row r;
        r.ch        = c;
        r.fin       = fin;
        r.typed     = typed;
        r.want.hz   = HZ_W'(hz);
        r.want.note = NOTE_W'(note);
        r.want.ms   = MS_W'(ms);
        r.want.last = 1'b1;
        return r;
    endfunction

    initial begin
        int  produced;
        int  sent;
        int  new_duration;
        int  new_octave;
        int  new_tempo;
        bit  paused;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        cfg_duration = DDUR_W'(RESET_DURATION);
        cfg_octave   = OCT_W'(RESET_OCTAVE);
        cfg_tempo    = BPM_W'(RESET_TEMPO);
        tok_phase    = PH_IDLE;
        open_token();

        // Directed melody under the reset settings.
        melody_script.push_back(step_row("a", 1'b0));
        melody_script.push_back(step_row(",", 1'b0, 1'b1, 1760, 93, 500));
        melody_script.push_back(step_row("8", 1'b0));
        melody_script.push_back(step_row("C", 1'b0));
        melody_script.push_back(step_row("#", 1'b0));
        melody_script.push_back(step_row("5", 1'b0));
        melody_script.push_back(step_row(".", 1'b0));
        melody_script.push_back(step_row(",", 1'b0));
        // Duration digits past the limit saturate.
        melody_script.push_back(step_row("9", 1'b0));
        melody_script.push_back(step_row("9", 1'b0));
        melody_script.push_back(step_row("9", 1'b0));
        melody_script.push_back(step_row("9", 1'b0));
        melody_script.push_back(step_row("P", 1'b0));
        melody_script.push_back(step_row(",", 1'b0, 1'b1, 0, 0, 2));
        // Unknown letters are silent; a new letter closes the open token.
        melody_script.push_back(step_row("Z", 1'b0));
        melody_script.push_back(step_row("h", 1'b0, 1'b1, 0, 0, 500));
        melody_script.push_back(step_row("#", 1'b0));
        melody_script.push_back(step_row("4", 1'b0));
        // Sharp after an octave closes the token and opens one more on the last character.
        melody_script.push_back(step_row("#", 1'b1));
        melody_script.push_back(step_row("b", 1'b0));
        melody_script.push_back(step_row(" ", 1'b1, 1'b1, 1975, 95, 500));
        melody_script.push_back(step_row("1", 1'b0));
        melody_script.push_back(step_row("6", 1'b1, 1'b1, 0, 0, 125));
        melody_script.push_back(step_row(8'hFF, 1'b0));
        melody_script.push_back(step_row(8'h00, 1'b0));
        melody_script.push_back(step_row("0", 1'b0));
        melody_script.push_back(step_row("e", 1'b1));

        foreach (melody_script[i]) begin
            send_char(melody_script[i].ch, melody_script[i].fin, produced);
            if (melody_script[i].typed) begin
                repeat (produced) void'(notes_due.pop_back());
                notes_due.push_back(melody_script[i].want);
            end
        end

        paused = 1'b0;
        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            drain();
            case (ph)
                0: begin
                    new_duration = 1;
                    new_octave   = 1;
                    new_tempo    = 1;
                end
                1: begin
                    new_duration = 255;
                    new_octave   = 9;
                    new_tempo    = 1023;
                end
                2: begin
                    // Zero divisors act as one; octaves above nine clamp to the top note.
                    new_duration = 0;
                    new_octave   = 15;
                    new_tempo    = 0;
                end
                3: begin
                    new_duration = 8;
                    new_octave   = 5;
                    new_tempo    = 63;
                end
                default: begin
                    new_duration = $urandom_range(255, 1);
                    new_octave   = $urandom_range(9, 1);
                    new_tempo    = $urandom_range(1023, 1);
                end
            endcase
            write_reg(REG_DEF_DUR, APB_DATA_W'(new_duration));
            write_reg(REG_DEF_OCT, APB_DATA_W'(new_octave));
            write_reg(REG_BPM, APB_DATA_W'(new_tempo));
            src_calm  = (ph == 1);
            sink_calm = (ph == 3);
            // The sender keeps offering characters while the result side holds off.
            if (ph == 1) stall_asked++;
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                play_tune(sent);
                if (ph == 4 && !paused && sent > PHASE_ITEMS / 2) begin
                    drain();
                    paused = 1'b1;
                end
            end
        end

        drain();
        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
